### hw/rtl/rcmr_pkg.sv
// Shared constants and controller/datapath interface types for the rod cutting block.
package rcmr_pkg;

  // Default sizing, handed down from the top level
  localparam int MAX_LEN_DEF    = 64;
  localparam int PRICE_BITS_DEF = 16;

  // Fixed port widths
  localparam int PRICE_PORT_BITS = 16;
  localparam int REV_BITS        = 22;
  localparam int LEN_BITS        = 7;

  // Revenue saturation value, all ones in REV_BITS
  localparam logic [REV_BITS-1:0] REV_CAP = {REV_BITS{1'b1}};

  // Commands from controller to datapath
  typedef struct packed {
    logic load;        // accept a price word
    logic solve_init;  // start the evaluation at length one
    logic issue;       // read one candidate and advance the cut
    logic wr_best;     // store best of the current length and advance
    logic out_load;    // capture the result and clear the table
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic cut_at_len;  // current cut equals current length
    logic len_at_n;    // current length equals the rod length
  } dp_stat_t;

endpackage

### hw/rtl/rcmr_dp.sv
// Datapath of the rod cutting block: price and best memories, counters, max accumulator.
module rcmr_dp import rcmr_pkg::*; #(
  parameter int MAX_LEN    = MAX_LEN_DEF,
  parameter int PRICE_BITS = PRICE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ctrl_cmd_t                  cmd,
  output dp_stat_t                   stat,
  input  logic [PRICE_PORT_BITS-1:0] in_piece_price,
  output logic [REV_BITS-1:0]        out_best_revenue,
  output logic [LEN_BITS-1:0]        out_rod_length,
  output logic                       out_overflow
);

  localparam int PW    = (PRICE_BITS < PRICE_PORT_BITS) ? PRICE_BITS : PRICE_PORT_BITS;
  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam int PA_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  logic [PW-1:0]       price_mem [MAX_LEN];
  logic [REV_BITS-1:0] best_mem  [MAX_LEN + 1];

  logic [CNT_W-1:0]    count_r;
  logic                ovf_r;
  logic [CNT_W-1:0]    len_r;
  logic [CNT_W-1:0]    cut_r;
  logic [REV_BITS-1:0] acc_r;
  logic                rd_valid_r;
  logic                best_zero_r;
  logic [PW-1:0]       rd_price_r;
  logic [REV_BITS-1:0] rd_best_r;
  logic [REV_BITS-1:0] last_best_r;

  logic                      room;
  logic [CNT_W-1:0]          cut_m1;
  logic [CNT_W-1:0]          best_idx;
  logic [REV_BITS:0]         cand_sum;
  logic [REV_BITS-1:0]       cand_sat;
  logic [REV_BITS-1:0]       acc_max;
  logic [REV_BITS-1:0]       best_term;
  logic [LEN_BITS+CNT_W-1:0] len_wide;

  assign room     = count_r < CNT_W'(MAX_LEN);
  assign cut_m1   = cut_r - CNT_W'(1);
  assign best_idx = len_r - cut_r;

  assign stat.cut_at_len = (cut_r == len_r);
  assign stat.len_at_n   = (len_r == count_r);

  // Best of the empty rod is zero and is never stored
  assign best_term = best_zero_r ? '0 : rd_best_r;
  assign cand_sum  = {1'b0, best_term} + {{(REV_BITS + 1 - PW){1'b0}}, rd_price_r};
  assign cand_sat  = cand_sum[REV_BITS] ? REV_CAP : cand_sum[REV_BITS-1:0];

  always_comb begin
    acc_max = acc_r;
    if (rd_valid_r && (cand_sat > acc_r)) begin
      acc_max = cand_sat;
    end
  end

  assign len_wide = {{LEN_BITS{1'b0}}, count_r};

  // Price memory: one write per accepted word while there is room
  always_ff @(posedge clk) begin
    if (cmd.load && room) begin
      price_mem[count_r[PA_W-1:0]] <= in_piece_price[PW-1:0];
    end
    if (cmd.issue) begin
      rd_price_r <= price_mem[cut_m1[PA_W-1:0]];
    end
  end

  // Best memory: write at the end of each length, read per cut
  always_ff @(posedge clk) begin
    if (cmd.wr_best) begin
      best_mem[len_r] <= acc_max;
    end
    if (cmd.issue) begin
      rd_best_r <= best_mem[best_idx];
    end
  end

  // Table count and overflow flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else if (cmd.out_load) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else if (cmd.load) begin
      if (room) begin
        count_r <= count_r + CNT_W'(1);
      end else begin
        ovf_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= cmd.issue;
    end
  end

  // Length and cut sequencing with the running maximum
  always_ff @(posedge clk) begin
    if (cmd.solve_init) begin
      len_r <= CNT_W'(1);
      cut_r <= CNT_W'(1);
      acc_r <= '0;
    end else if (cmd.wr_best) begin
      len_r       <= len_r + CNT_W'(1);
      cut_r       <= CNT_W'(1);
      acc_r       <= '0;
      last_best_r <= acc_max;
    end else begin
      acc_r <= acc_max;
      if (cmd.issue) begin
        cut_r <= cut_r + CNT_W'(1);
      end
    end
    if (cmd.issue) begin
      best_zero_r <= stat.cut_at_len;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_best_revenue <= last_best_r;
      out_rod_length   <= len_wide[LEN_BITS-1:0];
      out_overflow     <= ovf_r;
    end
  end

endmodule

### hw/rtl/rcmr_ctrl.sv
// Controller of the rod cutting block: load, evaluate and hand-off sequencing.
module rcmr_ctrl import rcmr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_last_entry,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_LOAD  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_WRITE = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_LOAD);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last_entry) begin
            cmd.solve_init = 1'b1;
            state_nxt      = S_ISSUE;
          end
        end
      end
      S_ISSUE: begin
        cmd.issue = 1'b1;
        if (stat.cut_at_len) begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.wr_best = 1'b1;
        state_nxt   = stat.len_at_n ? S_OUT : S_ISSUE;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### hw/rtl/rod_cutting_max_revenue.sv
// Top level of the rod cutting maximum revenue block: controller plus datapath.
//
//   channel  dir  handshake               payload
//   in       in   in_valid / in_ready     in_piece_price[15:0], in_last_entry
//   out      out  out_valid / out_ready   out_best_revenue[21:0], out_rod_length[6:0],
//                                         out_overflow
//
// Price words are accepted while in_ready is high. After the word marked last, the
// evaluation walks length L = 1..n and cut 1..L through one price-memory read
// port and one best-memory read port, plus one write per length, then moves the
// result into the output register. in_ready is low from the last word until the
// result is in the output register; a result waiting there does not stop loading
// of the next table. Reset (synchronous, active low) clears the controller, the
// word count and the overflow flag; the memories need no clearing since only
// entries written for the current table are read.
module rod_cutting_max_revenue import rcmr_pkg::*; #(
  parameter int MAX_LEN    = MAX_LEN_DEF,
  parameter int PRICE_BITS = PRICE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [PRICE_PORT_BITS-1:0] in_piece_price,
  input  logic                       in_last_entry,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [REV_BITS-1:0]        out_best_revenue,
  output logic [LEN_BITS-1:0]        out_rod_length,
  output logic                       out_overflow
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Sequence loading, per-cut reads, per-length writes and the result hand-off
  rcmr_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_last_entry (in_last_entry),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .stat          (stat),
    .cmd           (cmd)
  );

  // Hold the price and best tables and evaluate the recurrence one cut a cycle, with a write step after each length
  rcmr_dp #(
    .MAX_LEN    (MAX_LEN),
    .PRICE_BITS (PRICE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_piece_price   (in_piece_price),
    .out_best_revenue (out_best_revenue),
    .out_rod_length   (out_rod_length),
    .out_overflow     (out_overflow)
  );

endmodule

### tb/rod_cutting_max_revenue_tb.sv
// Self-checking testbench for the rod cutting maximum revenue block.
`timescale 1ns / 1ps

module rod_cutting_max_revenue_tb import rcmr_pkg::*; ();

  // How the prices of one generated table are shaped
  typedef enum int {
    PR_RANDOM,  // full 16-bit range, every bit toggles
    PR_SMALL,   // 0..15, lots of ties between cut plans
    PR_HIGH,    // near the top of the range, largest revenues
    PR_LINEAR   // roughly proportional to length, so cut choice matters
  } price_style_t;

  typedef struct {
    logic [REV_BITS-1:0] revenue;
    logic [LEN_BITS-1:0] length;
    logic                ovf;
  } cut_result_t;

  localparam int WORD_TARGET = 1800;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [PRICE_PORT_BITS-1:0] in_piece_price = '0;
  logic                       in_last_entry = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [REV_BITS-1:0]        out_best_revenue;
  logic [LEN_BITS-1:0]        out_rod_length;
  logic                       out_overflow;

  // Predictor state: price words of the table being loaded
  logic [PRICE_PORT_BITS-1:0] price_tab [MAX_LEN_DEF];
  int unsigned                words_held = 0;
  bit                         extra_seen = 1'b0;
  cut_result_t                revenue_due [$];

  // Run bookkeeping
  int unsigned words_sent = 0;
  int unsigned tables_sent = 0;
  int unsigned overflow_tables = 0;
  int unsigned full_tables = 0;
  int unsigned results_seen = 0;
  int unsigned bad_results = 0;
  int unsigned ready_hold = 0;
  bit          no_idle = 1'b0;

  rod_cutting_max_revenue dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_piece_price   (in_piece_price),
    .in_last_entry    (in_last_entry),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_best_revenue (out_best_revenue),
    .out_rod_length   (out_rod_length),
    .out_overflow     (out_overflow)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Evaluate best[L] = max over cuts i of price[i] + best[L - i], saturating at the
  // revenue cap; only the first n stored prices are ever read.
  function automatic logic [REV_BITS-1:0] best_cut_revenue(int unsigned n);
    logic [REV_BITS-1:0] best_at [MAX_LEN_DEF + 1];
    int unsigned         best;
    int unsigned         cand;
    best_at[0] = '0;
    for (int unsigned len = 1; len <= n; len++) begin
      best = 0;
      for (int unsigned cut = 1; cut <= len; cut++) begin
        cand = int'(price_tab[cut - 1]) + int'(best_at[len - cut]);
        if (cand > int'(REV_CAP)) cand = int'(REV_CAP);
        if (cand > best) best = cand;
      end
      best_at[len] = best[REV_BITS-1:0];
    end
    return best_at[n];
  endfunction

  // Track one accepted word; on the last word of a table queue the expected result
  // and clear the table.
  function automatic void price_word_taken(logic [PRICE_PORT_BITS-1:0] price,
                                           logic last);
    cut_result_t r;
    if (words_held < MAX_LEN_DEF) begin
      price_tab[words_held] = price;
      words_held++;
    end else begin
      extra_seen = 1'b1;
    end
    if (last) begin
      r.revenue = best_cut_revenue(words_held);
      r.length  = words_held[LEN_BITS-1:0];
      r.ovf     = extra_seen;
      revenue_due.push_back(r);
      if (extra_seen) overflow_tables++;
      if (words_held == MAX_LEN_DEF) full_tables++;
      tables_sent++;
      words_held = 0;
      extra_seen = 1'b0;
    end
  endfunction

  function automatic void note_mismatch(string what);
    bad_results++;
    if (bad_results <= 10) $display("MISMATCH at %0t: %s", $realtime, what);
  endfunction

  // Send one word: idle for a drawn gap, then hold valid and payload until taken.
  // Valid stays high across back-to-back words; the caller drops it at the end.
  task automatic send_word(logic [PRICE_PORT_BITS-1:0] price, logic last);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_piece_price <= price;
    in_last_entry  <= last;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    price_word_taken(price, last);
  endtask

  // Send a whole table of len words, last flag on the final one.
  task automatic send_table(int unsigned len, price_style_t style);
    logic [PRICE_PORT_BITS-1:0] price;
    int unsigned                base;
    int unsigned                raw;
    base = $urandom_range(1, 1000);
    for (int unsigned k = 1; k <= len; k++) begin
      case (style)
        PR_SMALL: begin
          price = PRICE_PORT_BITS'($urandom_range(0, 15));
        end
        PR_HIGH: begin
          price = PRICE_PORT_BITS'($urandom_range(16'hFFF0, 16'hFFFF));
        end
        PR_LINEAR: begin
          raw   = k * base + $urandom_range(0, base);
          price = (raw > 32'hFFFF) ? 16'hFFFF : raw[PRICE_PORT_BITS-1:0];
        end
        default: begin
          price = PRICE_PORT_BITS'($urandom_range(0, 16'hFFFF));
        end
      endcase
      send_word(price, k == len);
    end
  endtask

  function automatic price_style_t pick_style();
    case ($urandom_range(0, 3))
      0:       return PR_SMALL;
      1:       return PR_HIGH;
      2:       return PR_LINEAR;
      default: return PR_RANDOM;
    endcase
  endfunction

  // Hand-picked small tables: single entries at both price extremes, tables where
  // a cut wins and where the whole rod wins, all-zero prices, checkerboard bits.
  task automatic test_directed_cases();
    send_word(16'h0000, 1'b1);
    send_word(16'hFFFF, 1'b1);
    send_word(16'd1, 1'b0);
    send_word(16'd3, 1'b1);
    send_word(16'd5, 1'b0);
    send_word(16'd3, 1'b1);
    send_word(16'hFFFF, 1'b0);
    send_word(16'h0000, 1'b0);
    send_word(16'h0000, 1'b1);
    send_word(16'hAAAA, 1'b0);
    send_word(16'h5555, 1'b1);
    send_word(16'h0000, 1'b0);
    send_word(16'h0000, 1'b0);
    send_word(16'h0000, 1'b1);
  endtask

  // Tables at and beyond the length limit: exactly full, last word one past the
  // limit, a few extra words, and the largest possible revenue.
  task automatic test_full_and_overflow();
    send_table(MAX_LEN_DEF, PR_HIGH);
    send_table(MAX_LEN_DEF, PR_LINEAR);
    send_table(MAX_LEN_DEF + 1, PR_RANDOM);
    send_table(MAX_LEN_DEF + 5, PR_SMALL);
    for (int unsigned k = 1; k <= MAX_LEN_DEF; k++) send_word(16'hFFFF, 1'b0);
    send_word(16'h1234, 1'b0);
    send_word(16'hFFFF, 1'b1);
  endtask

  // Random tables until the word budget is used. Keep most tables short, since the
  // evaluation is quadratic in length; a few reach or pass the limit.
  task automatic test_random_tables();
    int unsigned pick;
    int unsigned len;
    while (words_sent < WORD_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 70)      len = $urandom_range(1, 8);
      else if (pick < 93) len = $urandom_range(9, 24);
      else if (pick < 98) len = $urandom_range(25, MAX_LEN_DEF - 1);
      else                len = $urandom_range(MAX_LEN_DEF, MAX_LEN_DEF + 8);
      // Run about a quarter of the tables with no idling on either side
      no_idle = ($urandom_range(0, 3) == 0);
      send_table(len, pick_style());
    end
    no_idle = 1'b0;
  endtask

  // Result side: stall a drawn number of cycles once a result is waiting, then take
  // it and compare each field with the oldest expectation.
  always @(posedge clk) begin
    cut_result_t want;
    if (!rst_n) begin
      ready_hold = 0;
    end else if (out_valid && out_ready) begin
      results_seen++;
      if (revenue_due.size() == 0) begin
        note_mismatch($sformatf("result with nothing expected: revenue %0d length %0d ovf %0b",
                                out_best_revenue, out_rod_length, out_overflow));
      end else begin
        want = revenue_due.pop_front();
        if (out_best_revenue !== want.revenue)
          note_mismatch($sformatf("best_revenue expected %0d got %0d",
                                  want.revenue, out_best_revenue));
        if (out_rod_length !== want.length)
          note_mismatch($sformatf("rod_length expected %0d got %0d",
                                  want.length, out_rod_length));
        if (out_overflow !== want.ovf)
          note_mismatch($sformatf("overflow expected %0b got %0b", want.ovf, out_overflow));
      end
      ready_hold = no_idle ? 0 : $urandom_range(0, 11);
    end else if (out_valid && ready_hold > 0) begin
      ready_hold--;
    end
    out_ready <= (ready_hold == 0);
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_full_and_overflow();
    test_random_tables();
    in_valid <= 1'b0;

    // Drain: every table ends in a last word, so nothing arrives after the final result
    while (revenue_due.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("Covered %0d price words in %0d tables (%0d full length, %0d overflowing).",
             words_sent, tables_sent, full_tables, overflow_tables);
    $display("Checked %0d results, %0d field mismatches.", results_seen, bad_results);
    if (bad_results == 0) begin
      $display("rod_cutting_max_revenue_tb: done, clean");
    end else begin
      $display("rod_cutting_max_revenue_tb: done, errors");
    end
    $finish;
  end

  // Hard stop for a hung handshake
  initial begin
    #2_000_000;
    $display("Timeout with %0d results still expected.", revenue_due.size());
    $display("rod_cutting_max_revenue_tb: done, errors");
    $finish;
  end

endmodule

### rod_cutting_max_revenue.f
hw/rtl/rcmr_pkg.sv
hw/rtl/rcmr_dp.sv
hw/rtl/rcmr_ctrl.sv
hw/rtl/rod_cutting_max_revenue.sv
tb/rod_cutting_max_revenue_tb.sv
